/* design/ast_pkg.sv */
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, token codes and byte classes for the assembly tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int KIND_BITS   = 5;
    localparam int OBUF_DEPTH  = 2;

    localparam logic [KIND_BITS-1:0] KIND_INVALID  = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_EOF      = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_NEWLINE  = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_SLASH    = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_STAR     = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_DOT      = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_COMMA    = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_COLON    = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_QUOTE    = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_NAME     = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_LABEL    = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_REG      = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_INT      = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_FLOAT    = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_STRING   = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_LCOMMENT = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_BCOMMENT = 5'd16;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NAME,
        ST_NUMBER,
        ST_REG,
        ST_SLASH,
        ST_NEWLINE,
        ST_LCOMMENT,
        ST_BCOMMENT,
        ST_STRING
    } t_scan_state;

    typedef struct packed {
        logic                   hex;
        logic                   dot;
        logic                   last_dot;
    } t_num_flags;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic                   err;
        logic                   last;
    } t_token;

    typedef struct packed {
        logic [1:0]             count;
        t_token                 tok0;
        t_token                 tok1;
    } t_push;

    function automatic logic is_letter(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] b);
        return b inside {[8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic is_name_byte(input logic [7:0] b);
        return is_letter(b) || is_digit(b) || (b == CH_UNDER);
    endfunction

endpackage

/* design/ast_if.sv */
// ----------------------------------------------------------------------------
// ast_if
// Valid/ready channels for source bytes and tokens.
// ----------------------------------------------------------------------------
interface ast_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface ast_out_if;
    logic                           valid;
    logic                           ready;
    logic [ast_pkg::KIND_BITS-1:0]   token_kind;
    logic [ast_pkg::OFFSET_BITS-1:0] start_offset;
    logic [ast_pkg::LENGTH_BITS-1:0] token_length;
    logic                           error_flag;
    logic                           last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output error_flag, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input start_offset,
                  input token_length, input error_flag, input last_of_run,
                  output ready);
endinterface

/* design/ast_scan.sv */
// ----------------------------------------------------------------------------
// ast_scan
// Input register, scanner state and next-token logic for one byte per cycle while the buffer has room.
// ----------------------------------------------------------------------------
module ast_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_char_byte,
    input  logic                  i_end_of_input,
    input  logic [1:0]            i_free,
    output logic                  o_ready,
    output ast_pkg::t_push        o_push
);

    logic                                r_in_valid;
    logic [7:0]                          r_byte;
    logic                                r_eoi;
    ast_pkg::t_scan_state                r_state, n_state;
    logic [ast_pkg::OFFSET_BITS-1:0]     r_pos, n_pos;
    logic [ast_pkg::OFFSET_BITS-1:0]     r_start, n_start;
    logic [ast_pkg::LENGTH_BITS-1:0]     r_count, n_count;
    ast_pkg::t_num_flags                 r_flags, n_flags;
    logic                                r_perr, n_perr;
    logic                                r_pstar, n_pstar;

    ast_pkg::t_scan_state                id_state;
    logic [ast_pkg::OFFSET_BITS-1:0]     id_start;
    logic [ast_pkg::LENGTH_BITS-1:0]     id_count;
    logic                                id_emit;
    logic [ast_pkg::KIND_BITS-1:0]       id_kind;
    logic [ast_pkg::LENGTH_BITS-1:0]     id_len;

    logic                                use_idle;
    logic                                a_vld, b_vld;
    ast_pkg::t_token                     a_tok, b_tok;
    logic [ast_pkg::LENGTH_BITS-1:0]     cnt_inc;
    logic                                num_takes;
    logic [1:0]                          res_n;
    logic                                advance;

    assign cnt_inc = r_count + ast_pkg::LENGTH_BITS'(1);

    // scan of the current byte from idle
    always_comb begin
        id_state = ast_pkg::ST_IDLE;
        id_start = r_pos;
        id_count = ast_pkg::LENGTH_BITS'(1);
        id_emit  = 1'b0;
        id_kind  = ast_pkg::KIND_INVALID;
        id_len   = ast_pkg::LENGTH_BITS'(1);
        if ((r_byte == ast_pkg::CH_SPACE) || (r_byte == ast_pkg::CH_TAB)) begin
            id_state = ast_pkg::ST_IDLE;
        end else if (ast_pkg::is_letter(r_byte)) begin
            id_state = ast_pkg::ST_NAME;
        end else if ((r_byte == ast_pkg::CH_MINUS) || ast_pkg::is_digit(r_byte)) begin
            id_state = ast_pkg::ST_NUMBER;
        end else if (r_byte == ast_pkg::CH_PCT) begin
            id_state = ast_pkg::ST_REG;
        end else if (r_byte == ast_pkg::CH_SLASH) begin
            id_state = ast_pkg::ST_SLASH;
        end else if (r_byte == ast_pkg::CH_LF) begin
            id_state = ast_pkg::ST_NEWLINE;
        end else if (r_byte == ast_pkg::CH_DQUOTE) begin
            id_state = ast_pkg::ST_STRING;
            id_start = r_pos + ast_pkg::OFFSET_BITS'(1);
            id_count = '0;
        end else begin
            id_emit = 1'b1;
            case (r_byte)
                ast_pkg::CH_STAR:   id_kind = ast_pkg::KIND_STAR;
                ast_pkg::CH_DOT:    id_kind = ast_pkg::KIND_DOT;
                ast_pkg::CH_COMMA:  id_kind = ast_pkg::KIND_COMMA;
                ast_pkg::CH_COLON:  id_kind = ast_pkg::KIND_COLON;
                ast_pkg::CH_SQUOTE: id_kind = ast_pkg::KIND_QUOTE;
                default: begin
                    id_kind = ast_pkg::KIND_INVALID;
                    id_len  = '0;
                end
            endcase
        end
    end

    assign num_takes = (r_byte == ast_pkg::CH_X) || (r_byte == ast_pkg::CH_DOT)
                    || ast_pkg::is_digit(r_byte)
                    || (r_flags.hex && ast_pkg::is_hex_letter(r_byte));

    // pending token and state update
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos + ast_pkg::OFFSET_BITS'(1);
        n_start  = r_start;
        n_count  = r_count;
        n_flags  = r_flags;
        n_perr   = r_perr;
        n_pstar  = r_pstar;
        use_idle = 1'b0;
        a_vld    = 1'b0;
        a_tok    = '{kind: ast_pkg::KIND_INVALID, start: r_start, length: r_count,
                     err: 1'b0, last: 1'b0};
        b_vld    = 1'b0;
        b_tok    = '{kind: id_kind, start: r_pos, length: id_len, err: 1'b0, last: 1'b0};
        if (r_eoi) begin
            n_pos   = r_pos;
            n_state = ast_pkg::ST_IDLE;
            a_vld   = (r_state != ast_pkg::ST_IDLE);
            case (r_state)
                ast_pkg::ST_NAME:     a_tok.kind = ast_pkg::KIND_NAME;
                ast_pkg::ST_NUMBER: begin
                    a_tok.kind = r_flags.dot ? ast_pkg::KIND_FLOAT : ast_pkg::KIND_INT;
                    a_tok.err  = r_perr;
                end
                ast_pkg::ST_REG:      a_tok.kind = ast_pkg::KIND_REG;
                ast_pkg::ST_SLASH: begin
                    a_tok.kind   = ast_pkg::KIND_SLASH;
                    a_tok.length = ast_pkg::LENGTH_BITS'(1);
                end
                ast_pkg::ST_NEWLINE: begin
                    a_tok.kind   = ast_pkg::KIND_NEWLINE;
                    a_tok.length = ast_pkg::LENGTH_BITS'(1);
                end
                ast_pkg::ST_LCOMMENT: a_tok.kind = ast_pkg::KIND_LCOMMENT;
                ast_pkg::ST_BCOMMENT: begin
                    a_tok.kind = ast_pkg::KIND_BCOMMENT;
                    a_tok.err  = 1'b1;
                end
                ast_pkg::ST_STRING: begin
                    a_tok.kind = ast_pkg::KIND_STRING;
                    a_tok.err  = 1'b1;
                end
                default: a_vld = 1'b0;
            endcase
            b_vld = 1'b1;
            b_tok = '{kind: ast_pkg::KIND_EOF, start: r_pos, length: '0,
                      err: 1'b0, last: 1'b0};
        end else begin
            case (r_state)
                ast_pkg::ST_NAME: begin
                    if (ast_pkg::is_name_byte(r_byte)) begin
                        n_count = cnt_inc;
                    end else if (r_byte == ast_pkg::CH_COLON) begin
                        a_vld        = 1'b1;
                        a_tok.kind   = ast_pkg::KIND_LABEL;
                        a_tok.length = cnt_inc;
                        n_state      = ast_pkg::ST_IDLE;
                    end else begin
                        a_vld      = 1'b1;
                        a_tok.kind = ast_pkg::KIND_NAME;
                        use_idle   = 1'b1;
                    end
                end
                ast_pkg::ST_NUMBER: begin
                    if (num_takes) begin
                        n_count = cnt_inc;
                        if (r_byte == ast_pkg::CH_X) begin
                            n_flags.hex = 1'b1;
                        end else if (r_byte == ast_pkg::CH_DOT) begin
                            n_perr           = r_perr | r_flags.last_dot;
                            n_flags.dot      = 1'b1;
                            n_flags.last_dot = 1'b1;
                        end else begin
                            n_flags.last_dot = 1'b0;
                        end
                    end else begin
                        a_vld      = 1'b1;
                        a_tok.kind = r_flags.dot ? ast_pkg::KIND_FLOAT : ast_pkg::KIND_INT;
                        a_tok.err  = r_perr;
                        use_idle   = 1'b1;
                    end
                end
                ast_pkg::ST_REG: begin
                    if (ast_pkg::is_name_byte(r_byte)) begin
                        n_count = cnt_inc;
                    end else begin
                        a_vld      = 1'b1;
                        a_tok.kind = ast_pkg::KIND_REG;
                        use_idle   = 1'b1;
                    end
                end
                ast_pkg::ST_SLASH: begin
                    if (r_byte == ast_pkg::CH_SLASH) begin
                        n_state = ast_pkg::ST_LCOMMENT;
                        n_count = ast_pkg::LENGTH_BITS'(2);
                    end else if (r_byte == ast_pkg::CH_STAR) begin
                        n_state = ast_pkg::ST_BCOMMENT;
                        n_count = ast_pkg::LENGTH_BITS'(2);
                        n_pstar = 1'b0;
                    end else begin
                        a_vld        = 1'b1;
                        a_tok.kind   = ast_pkg::KIND_SLASH;
                        a_tok.length = ast_pkg::LENGTH_BITS'(1);
                        use_idle     = 1'b1;
                    end
                end
                ast_pkg::ST_NEWLINE: begin
                    if (r_byte != ast_pkg::CH_LF) begin
                        a_vld        = 1'b1;
                        a_tok.kind   = ast_pkg::KIND_NEWLINE;
                        a_tok.length = ast_pkg::LENGTH_BITS'(1);
                        use_idle     = 1'b1;
                    end
                end
                ast_pkg::ST_LCOMMENT: begin
                    if (r_byte == ast_pkg::CH_LF) begin
                        a_vld      = 1'b1;
                        a_tok.kind = ast_pkg::KIND_LCOMMENT;
                        n_state    = ast_pkg::ST_IDLE;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                ast_pkg::ST_BCOMMENT: begin
                    n_count = cnt_inc;
                    if (r_pstar && (r_byte == ast_pkg::CH_SLASH)) begin
                        a_vld        = 1'b1;
                        a_tok.kind   = ast_pkg::KIND_BCOMMENT;
                        a_tok.length = cnt_inc;
                        n_state      = ast_pkg::ST_IDLE;
                        n_pstar      = 1'b0;
                    end else begin
                        n_pstar = (r_byte == ast_pkg::CH_STAR);
                    end
                end
                ast_pkg::ST_STRING: begin
                    if (r_byte == ast_pkg::CH_DQUOTE) begin
                        a_vld      = 1'b1;
                        a_tok.kind = ast_pkg::KIND_STRING;
                        a_tok.err  = r_perr;
                        n_state    = ast_pkg::ST_IDLE;
                    end else begin
                        n_count = cnt_inc;
                        n_perr  = r_perr | (r_byte == ast_pkg::CH_LF);
                    end
                end
                default: use_idle = 1'b1;
            endcase
            if (use_idle) begin
                n_state = id_state;
                n_start = id_start;
                n_count = id_count;
                n_perr  = 1'b0;
                b_vld   = id_emit;
                if (id_state == ast_pkg::ST_NUMBER) begin
                    n_flags = '0;
                end
            end
        end
    end

    // pack up to two tokens, marking the final one of the item
    always_comb begin
        res_n       = {1'b0, a_vld} + {1'b0, b_vld};
        o_push      = '0;
        o_push.count = r_in_valid ? res_n : 2'd0;
        if (a_vld) begin
            o_push.tok0      = a_tok;
            o_push.tok0.last = !b_vld;
            o_push.tok1      = b_tok;
            o_push.tok1.last = 1'b1;
        end else begin
            o_push.tok0      = b_tok;
            o_push.tok0.last = 1'b1;
        end
        if (!advance) begin
            o_push.count = 2'd0;
        end
    end

    assign advance = r_in_valid && (res_n <= i_free);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_char_byte;
            r_eoi  <= i_end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ast_pkg::ST_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_count <= '0;
            r_flags <= '0;
            r_perr  <= 1'b0;
            r_pstar <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_count <= n_count;
            r_flags <= n_flags;
            r_perr  <= n_perr;
            r_pstar <= n_pstar;
        end
    end

endmodule

/* design/ast_obuf.sv */
// ----------------------------------------------------------------------------
// ast_obuf
// Two-entry token buffer: takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module ast_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ast_pkg::t_push    i_push,
    input  logic              i_pop,
    output logic [1:0]        o_free,
    output logic              o_valid,
    output ast_pkg::t_token   o_head
);

    ast_pkg::t_token r_slot [ast_pkg::OBUF_DEPTH];
    ast_pkg::t_token n_slot [ast_pkg::OBUF_DEPTH];
    logic [1:0]      r_count, n_count;
    logic [1:0]      kept;

    always_comb begin
        n_slot = r_slot;
        kept   = r_count;
        if (i_pop && (r_count != 2'd0)) begin
            n_slot[0] = r_slot[1];
            kept      = r_count - 2'd1;
        end
        if (i_push.count == 2'd2) begin
            n_slot[0] = i_push.tok0;
            n_slot[1] = i_push.tok1;
        end else if (i_push.count == 2'd1) begin
            n_slot[kept[0]] = i_push.tok0;
        end
        n_count = kept + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_free  = 2'(ast_pkg::OBUF_DEPTH) - r_count;
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot[0];

endmodule

/* design/assembly_source_tokenizer.sv */
// ----------------------------------------------------------------------------
// assembly_source_tokenizer
// Lexer for assembler source: one byte or end mark per item in, tokens out.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         handshake
//  i_in      in   char_byte, end_of_input                         valid/ready
//  o_out     out  token_kind, start_offset, token_length,         valid/ready
//                 error_flag, last_of_run
//
//  one source item per cycle while the token buffer has room; the scanner
//  sits between an input register and a two-entry token buffer
//  an item giving two tokens waits until the buffer is empty, and the next
//  item that gives a token then waits for a free slot
//  in_ready does not depend on o_out.ready in the same cycle
//  synchronous active-low reset returns the scanner to idle at offset zero
// ----------------------------------------------------------------------------
module assembly_source_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ast_in_if.sink     i_in,
    ast_out_if.source  o_out
);

    ast_pkg::t_push  push;
    ast_pkg::t_token head;
    logic [1:0]      free;
    logic            head_valid;

    ast_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .i_char_byte    (i_in.char_byte),
        .i_end_of_input (i_in.end_of_input),
        .i_free         (free),
        .o_ready        (i_in.ready),
        .o_push         (push)
    );

    ast_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_free  (free),
        .o_valid (head_valid),
        .o_head  (head)
    );

    assign o_out.valid        = head_valid;
    assign o_out.token_kind   = head.kind;
    assign o_out.start_offset = head.start;
    assign o_out.token_length = head.length;
    assign o_out.error_flag   = head.err;
    assign o_out.last_of_run  = head.last;

endmodule

/* design/ast_checker.sv */
// ----------------------------------------------------------------------------
// ast_checker
// Port-level checks on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ast_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ast_pkg::KIND_BITS-1:0]   i_kind,
    input logic [ast_pkg::OFFSET_BITS-1:0] i_start,
    input logic [ast_pkg::LENGTH_BITS-1:0] i_length,
    input logic                            i_err,
    input logic                            i_last
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("token valid right after reset");

    // end of input always closes the item's run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == ast_pkg::KIND_EOF)) |-> (i_last && (i_length == '0)))
        else $error("eof token not last or not empty");

    // errors only on numbers, strings and block comments
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_err) |->
            ((i_kind == ast_pkg::KIND_INT) || (i_kind == ast_pkg::KIND_FLOAT) ||
             (i_kind == ast_pkg::KIND_STRING) || (i_kind == ast_pkg::KIND_BCOMMENT)))
        else $error("error flag on wrong token kind");

    // unknown bytes give an empty token
    a_invalid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == ast_pkg::KIND_INVALID)) |-> (i_length == '0))
        else $error("invalid token with nonzero length");

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_kind) && $stable(i_start) && $stable(i_length)))
        else $error("stalled token changed");

endmodule

bind assembly_source_tokenizer ast_checker u_ast_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.token_kind),
    .i_start     (o_out.start_offset),
    .i_length    (o_out.token_length),
    .i_err       (o_out.error_flag),
    .i_last      (o_out.last_of_run)
);

/* bench/assembly_source_tokenizer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_test
// Feeds source bytes and end marks through the tokenizer's input channel and
// checks each token against a cycle-free lexer model in the bench or a token
// given by the table. A short table of hand-picked bytes comes first, then
// random fragments of names, labels, registers, numbers, strings, comments,
// punctuation and noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_test;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic SRC_ITEM = 1'b0;
    localparam logic END_ITEM = 1'b1;
    localparam logic PRED     = 1'b0;
    localparam logic TYPED    = 1'b1;
    localparam ast_pkg::t_token NO_TOK = '0;

    typedef struct packed {
        logic [7:0]      ch;
        logic            eoi;
        logic            typed;
        ast_pkg::t_token tok;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ast_in_if  src_if ();
    ast_out_if tok_if ();

    assembly_source_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (src_if),
        .o_out   (tok_if)
    );

    always #5 i_clk = ~i_clk;

    // lexer model state
    ast_pkg::t_scan_state            scan_st;
    logic [ast_pkg::OFFSET_BITS-1:0] byte_pos;
    logic [ast_pkg::OFFSET_BITS-1:0] tok_start;
    logic [ast_pkg::LENGTH_BITS-1:0] tok_len;
    logic                            num_hex;
    logic                            num_dot;
    logic                            num_last_dot;
    logic                            bad_token;
    logic                            star_seen;

    ast_pkg::t_token step_tokens[$];
    ast_pkg::t_token pending_tokens[$];
    logic [8:0]      frag_bytes[$];

    logic  idle_on;
    int    fail_count;
    int    items_sent;
    int    end_marks;
    int    tokens_seen;
    int    errors_seen;
    int    cycle_count;
    logic [31:0] kinds_seen;

    t_dir_row dir_table [30] = '{
        {8'h00,     END_ITEM, TYPED, {ast_pkg::KIND_EOF, 32'd0, 16'd0, 1'b0, 1'b1}},
        {"a",       SRC_ITEM, PRED,  NO_TOK},
        {":",       SRC_ITEM, TYPED, {ast_pkg::KIND_LABEL, 32'd0, 16'd2, 1'b0, 1'b1}},
        {"%",       SRC_ITEM, PRED,  NO_TOK},
        {"r",       SRC_ITEM, PRED,  NO_TOK},
        {",",       SRC_ITEM, PRED,  NO_TOK},
        {"-",       SRC_ITEM, PRED,  NO_TOK},
        {"x",       SRC_ITEM, PRED,  NO_TOK},
        {"f",       SRC_ITEM, PRED,  NO_TOK},
        {".",       SRC_ITEM, PRED,  NO_TOK},
        {".",       SRC_ITEM, PRED,  NO_TOK},
        {ast_pkg::CH_SPACE,  SRC_ITEM, TYPED,
            {ast_pkg::KIND_FLOAT, 32'd5, 16'd5, 1'b1, 1'b1}},
        {ast_pkg::CH_DQUOTE, SRC_ITEM, PRED,  NO_TOK},
        {ast_pkg::CH_LF,     SRC_ITEM, PRED,  NO_TOK},
        {ast_pkg::CH_DQUOTE, SRC_ITEM, TYPED,
            {ast_pkg::KIND_STRING, 32'd12, 16'd1, 1'b1, 1'b1}},
        {"/",       SRC_ITEM, PRED,  NO_TOK},
        {"*",       SRC_ITEM, PRED,  NO_TOK},
        {"/",       SRC_ITEM, PRED,  NO_TOK},
        {"*",       SRC_ITEM, PRED,  NO_TOK},
        {"/",       SRC_ITEM, PRED,  NO_TOK},
        {8'hFF,     SRC_ITEM, TYPED, {ast_pkg::KIND_INVALID, 32'd19, 16'd0, 1'b0, 1'b1}},
        {ast_pkg::CH_LF,     SRC_ITEM, PRED,  NO_TOK},
        {ast_pkg::CH_LF,     SRC_ITEM, PRED,  NO_TOK},
        {"-",       SRC_ITEM, PRED,  NO_TOK},
        {"*",       SRC_ITEM, PRED,  NO_TOK},
        {"/",       SRC_ITEM, PRED,  NO_TOK},
        {"/",       SRC_ITEM, PRED,  NO_TOK},
        {ast_pkg::CH_LF,     SRC_ITEM, PRED,  NO_TOK},
        {ast_pkg::CH_DQUOTE, SRC_ITEM, PRED,  NO_TOK},
        {8'h00,     END_ITEM, PRED,  NO_TOK}
    };

    function automatic logic alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic word_byte(input logic [7:0] b);
        return alpha(b) || numeral(b) || b == ast_pkg::CH_UNDER;
    endfunction

    task automatic note_token(input logic [ast_pkg::KIND_BITS-1:0] kind,
                              input logic [ast_pkg::OFFSET_BITS-1:0] start,
                              input logic [ast_pkg::LENGTH_BITS-1:0] len,
                              input logic err);
        ast_pkg::t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.err    = err;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic open_token(input logic [7:0] b);
        tok_start = byte_pos;
        tok_len   = 1;
        bad_token = 1'b0;
        if (alpha(b)) begin
            scan_st = ast_pkg::ST_NAME;
        end else if (b == ast_pkg::CH_MINUS || numeral(b)) begin
            scan_st      = ast_pkg::ST_NUMBER;
            num_hex      = 1'b0;
            num_dot      = 1'b0;
            num_last_dot = 1'b0;
        end else if (b == ast_pkg::CH_PCT) begin
            scan_st = ast_pkg::ST_REG;
        end else if (b == ast_pkg::CH_SLASH) begin
            scan_st = ast_pkg::ST_SLASH;
        end else if (b == ast_pkg::CH_LF) begin
            scan_st = ast_pkg::ST_NEWLINE;
        end else if (b == ast_pkg::CH_DQUOTE) begin
            scan_st   = ast_pkg::ST_STRING;
            tok_start = byte_pos + 1;
            tok_len   = 0;
        end else if (b == ast_pkg::CH_STAR) begin
            note_token(ast_pkg::KIND_STAR, byte_pos, 1, 1'b0);
        end else if (b == ast_pkg::CH_DOT) begin
            note_token(ast_pkg::KIND_DOT, byte_pos, 1, 1'b0);
        end else if (b == ast_pkg::CH_COMMA) begin
            note_token(ast_pkg::KIND_COMMA, byte_pos, 1, 1'b0);
        end else if (b == ast_pkg::CH_COLON) begin
            note_token(ast_pkg::KIND_COLON, byte_pos, 1, 1'b0);
        end else if (b == ast_pkg::CH_SQUOTE) begin
            note_token(ast_pkg::KIND_QUOTE, byte_pos, 1, 1'b0);
        end else if (b != ast_pkg::CH_SPACE && b != ast_pkg::CH_TAB) begin
            note_token(ast_pkg::KIND_INVALID, byte_pos, 0, 1'b0);
        end
    endtask

    // tokens caused by one item land in step_tokens
    task automatic lex_item(input logic [7:0] b, input logic eoi);
        logic [ast_pkg::KIND_BITS-1:0] num_kind;
        step_tokens.delete();
        num_kind = num_dot ? ast_pkg::KIND_FLOAT : ast_pkg::KIND_INT;
        if (eoi) begin
            case (scan_st)
                ast_pkg::ST_NAME:
                    note_token(ast_pkg::KIND_NAME, tok_start, tok_len, 1'b0);
                ast_pkg::ST_NUMBER:
                    note_token(num_kind, tok_start, tok_len, bad_token);
                ast_pkg::ST_REG:
                    note_token(ast_pkg::KIND_REG, tok_start, tok_len, 1'b0);
                ast_pkg::ST_SLASH:
                    note_token(ast_pkg::KIND_SLASH, tok_start, 1, 1'b0);
                ast_pkg::ST_NEWLINE:
                    note_token(ast_pkg::KIND_NEWLINE, tok_start, 1, 1'b0);
                ast_pkg::ST_LCOMMENT:
                    note_token(ast_pkg::KIND_LCOMMENT, tok_start, tok_len, 1'b0);
                ast_pkg::ST_BCOMMENT:
                    note_token(ast_pkg::KIND_BCOMMENT, tok_start, tok_len, 1'b1);
                ast_pkg::ST_STRING:
                    note_token(ast_pkg::KIND_STRING, tok_start, tok_len, 1'b1);
                default: ;
            endcase
            scan_st = ast_pkg::ST_IDLE;
            note_token(ast_pkg::KIND_EOF, byte_pos, 0, 1'b0);
        end else begin
            case (scan_st)
                ast_pkg::ST_NAME: begin
                    if (word_byte(b)) begin
                        tok_len++;
                    end else if (b == ast_pkg::CH_COLON) begin
                        note_token(ast_pkg::KIND_LABEL, tok_start, tok_len + 1'b1, 1'b0);
                        scan_st = ast_pkg::ST_IDLE;
                    end else begin
                        note_token(ast_pkg::KIND_NAME, tok_start, tok_len, 1'b0);
                        scan_st = ast_pkg::ST_IDLE;
                        open_token(b);
                    end
                end
                ast_pkg::ST_NUMBER: begin
                    if (b == ast_pkg::CH_X) begin
                        num_hex = 1'b1;
                        tok_len++;
                    end else if (b == ast_pkg::CH_DOT) begin
                        if (num_last_dot) bad_token = 1'b1;
                        num_dot      = 1'b1;
                        num_last_dot = 1'b1;
                        tok_len++;
                    end else if (numeral(b) || (num_hex && ((b >= "A" && b <= "F") ||
                                                            (b >= "a" && b <= "f")))) begin
                        num_last_dot = 1'b0;
                        tok_len++;
                    end else begin
                        note_token(num_kind, tok_start, tok_len, bad_token);
                        scan_st = ast_pkg::ST_IDLE;
                        open_token(b);
                    end
                end
                ast_pkg::ST_REG: begin
                    if (word_byte(b)) begin
                        tok_len++;
                    end else begin
                        note_token(ast_pkg::KIND_REG, tok_start, tok_len, 1'b0);
                        scan_st = ast_pkg::ST_IDLE;
                        open_token(b);
                    end
                end
                ast_pkg::ST_SLASH: begin
                    if (b == ast_pkg::CH_SLASH) begin
                        scan_st = ast_pkg::ST_LCOMMENT;
                        tok_len = 2;
                    end else if (b == ast_pkg::CH_STAR) begin
                        scan_st   = ast_pkg::ST_BCOMMENT;
                        tok_len   = 2;
                        star_seen = 1'b0;
                    end else begin
                        note_token(ast_pkg::KIND_SLASH, tok_start, 1, 1'b0);
                        scan_st = ast_pkg::ST_IDLE;
                        open_token(b);
                    end
                end
                ast_pkg::ST_NEWLINE: begin
                    if (b != ast_pkg::CH_LF) begin
                        note_token(ast_pkg::KIND_NEWLINE, tok_start, 1, 1'b0);
                        scan_st = ast_pkg::ST_IDLE;
                        open_token(b);
                    end
                end
                ast_pkg::ST_LCOMMENT: begin
                    if (b == ast_pkg::CH_LF) begin
                        note_token(ast_pkg::KIND_LCOMMENT, tok_start, tok_len, 1'b0);
                        scan_st = ast_pkg::ST_IDLE;
                    end else begin
                        tok_len++;
                    end
                end
                ast_pkg::ST_BCOMMENT: begin
                    tok_len++;
                    if (star_seen && b == ast_pkg::CH_SLASH) begin
                        note_token(ast_pkg::KIND_BCOMMENT, tok_start, tok_len, 1'b0);
                        scan_st   = ast_pkg::ST_IDLE;
                        star_seen = 1'b0;
                    end else begin
                        star_seen = (b == ast_pkg::CH_STAR);
                    end
                end
                ast_pkg::ST_STRING: begin
                    if (b == ast_pkg::CH_DQUOTE) begin
                        note_token(ast_pkg::KIND_STRING, tok_start, tok_len, bad_token);
                        scan_st = ast_pkg::ST_IDLE;
                    end else begin
                        tok_len++;
                        if (b == ast_pkg::CH_LF) bad_token = 1'b1;
                    end
                end
                default: begin
                    scan_st = ast_pkg::ST_IDLE;
                    open_token(b);
                end
            endcase
            byte_pos++;
        end
    endtask

    // drive one item, wait for acceptance, then book its tokens
    task automatic feed(input logic [7:0] b, input logic eoi,
                        input logic typed, input ast_pkg::t_token tok);
        int gap;
        ast_pkg::t_token t;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            src_if.valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
        src_if.valid        = 1'b1;
        src_if.char_byte    = b;
        src_if.end_of_input = eoi;
        do @(posedge i_clk); while (!src_if.ready);
        @(negedge i_clk);
        lex_item(b, eoi);
        if (typed) begin
            pending_tokens.push_back(tok);
        end else begin
            foreach (step_tokens[i]) begin
                t = step_tokens[i];
                t.last = (i == step_tokens.size() - 1);
                pending_tokens.push_back(t);
            end
        end
        items_sent++;
        if (eoi) end_marks++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        frag_bytes.push_back({SRC_ITEM, b});
    endtask

    function automatic logic [7:0] rand_word_byte();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return ast_pkg::CH_UNDER;
    endfunction

    task automatic make_fragment();
        int r;
        int h;
        logic minus;
        r = $urandom_range(0, 99);
        if (r < 16) begin
            queue_byte(8'("a" + $urandom_range(0, 25)) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
            repeat ($urandom_range(0, 6)) queue_byte(rand_word_byte());
            if ($urandom_range(0, 4) < 2) queue_byte(ast_pkg::CH_COLON);
        end else if (r < 24) begin
            queue_byte(ast_pkg::CH_PCT);
            repeat ($urandom_range(0, 4)) queue_byte(rand_word_byte());
        end else if (r < 40) begin
            minus = ($urandom_range(0, 2) == 0);
            if (minus) queue_byte(ast_pkg::CH_MINUS);
            repeat ($urandom_range(minus ? 0 : 1, 4)) queue_byte(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) begin
                queue_byte(ast_pkg::CH_X);
                repeat ($urandom_range(1, 3)) begin
                    h = $urandom_range(0, 21);
                    queue_byte(h < 10 ? 8'("0" + h) : h < 16 ? 8'("A" + h - 10) : 8'("a" + h - 16));
                end
            end
            h = $urandom_range(0, 9);
            if (h < 3) begin
                queue_byte(ast_pkg::CH_DOT);
                repeat ($urandom_range(0, 3)) queue_byte(8'("0" + $urandom_range(0, 9)));
            end else if (h == 3) begin
                queue_byte(ast_pkg::CH_DOT);
                queue_byte(ast_pkg::CH_DOT);
                if ($urandom_range(0, 1)) queue_byte(8'("0" + $urandom_range(0, 9)));
            end
        end else if (r < 50) begin
            queue_byte(ast_pkg::CH_DQUOTE);
            repeat ($urandom_range(0, 6)) begin
                h = $urandom_range(0, 19);
                if (h == 0) queue_byte(ast_pkg::CH_LF);
                else if (h == 1) queue_byte(8'($urandom_range(128, 255)));
                else queue_byte(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 9) != 0) queue_byte(ast_pkg::CH_DQUOTE);
        end else if (r < 57) begin
            queue_byte(ast_pkg::CH_SLASH);
            queue_byte(ast_pkg::CH_SLASH);
            repeat ($urandom_range(0, 6)) queue_byte(8'($urandom_range(0, 255)));
            queue_byte(ast_pkg::CH_LF);
        end else if (r < 64) begin
            queue_byte(ast_pkg::CH_SLASH);
            queue_byte(ast_pkg::CH_STAR);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 9) < 3) queue_byte(ast_pkg::CH_STAR);
                else queue_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) != 0) begin
                queue_byte(ast_pkg::CH_STAR);
                queue_byte(ast_pkg::CH_SLASH);
            end
        end else if (r < 80) begin
            case ($urandom_range(0, 7))
                0: queue_byte(ast_pkg::CH_STAR);
                1: queue_byte(ast_pkg::CH_DOT);
                2: queue_byte(ast_pkg::CH_COMMA);
                3: queue_byte(ast_pkg::CH_COLON);
                4: queue_byte(ast_pkg::CH_SQUOTE);
                5: queue_byte(ast_pkg::CH_SLASH);
                6: queue_byte(ast_pkg::CH_LF);
                default: begin
                    queue_byte(ast_pkg::CH_LF);
                    queue_byte(ast_pkg::CH_LF);
                end
            endcase
        end else if (r < 88) begin
            repeat ($urandom_range(1, 2))
                queue_byte($urandom_range(0, 1) ? ast_pkg::CH_SPACE : ast_pkg::CH_TAB);
        end else if (r < 96) begin
            queue_byte(8'($urandom_range(0, 255)));
        end else begin
            frag_bytes.push_back({END_ITEM, 8'($urandom_range(0, 255))});
        end
    endtask

    // token checker
    always @(posedge i_clk) begin : token_check
        ast_pkg::t_token got;
        ast_pkg::t_token want;
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            got.kind   = tok_if.token_kind;
            got.start  = tok_if.start_offset;
            got.length = tok_if.token_length;
            got.err    = tok_if.error_flag;
            got.last   = tok_if.last_of_run;
            tokens_seen++;
            kinds_seen[got.kind] = 1'b1;
            if (got.err) errors_seen++;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token kind %0d start %0d length %0d err %0b last %0b",
                         $time, got.kind, got.start, got.length, got.err, got.last);
                fail_count++;
            end else begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.length !== want.length || got.err !== want.err ||
                    got.last !== want.last) begin
                    $display("%0t: token mismatch, expected kind %0d start %0d length %0d err %0b last %0b",
                             $time, want.kind, want.start, want.length, want.err, want.last);
                    $display("%0t:                   got kind %0d start %0d length %0d err %0b last %0b",
                             $time, got.kind, got.start, got.length, got.err, got.last);
                    fail_count++;
                end
            end
        end
    end

    // token sink with stall bursts
    initial begin
        int hold;
        hold = 0;
        tok_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                tok_if.ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 3) - 1;
                tok_if.ready = 1'b0;
            end else begin
                tok_if.ready = 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("assembly_source_tokenizer_test failed");
        $finish;
    end

    initial begin
        int counted;
        logic [8:0] item;
        i_rst_n             = 1'b0;
        src_if.valid        = 1'b0;
        src_if.char_byte    = 8'h00;
        src_if.end_of_input = 1'b0;
        idle_on      = 1'b1;
        fail_count   = 0;
        items_sent   = 0;
        end_marks    = 0;
        tokens_seen  = 0;
        errors_seen  = 0;
        kinds_seen   = '0;
        scan_st      = ast_pkg::ST_IDLE;
        byte_pos     = '0;
        tok_start    = '0;
        tok_len      = '0;
        num_hex      = 1'b0;
        num_dot      = 1'b0;
        num_last_dot = 1'b0;
        bad_token    = 1'b0;
        star_seen    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[i])
            feed(dir_table[i].ch, dir_table[i].eoi, dir_table[i].typed, dir_table[i].tok);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (counted > RANDOM_ITEMS * 85 / 100) idle_on = 1'b0;
            if (counted == RANDOM_ITEMS / 2) begin
                src_if.valid = 1'b0;
                while (pending_tokens.size() != 0) @(negedge i_clk);
            end
            if (frag_bytes.size() == 0) make_fragment();
            item = frag_bytes.pop_front();
            feed(item[7:0], item[8], PRED, NO_TOK);
            if (item[8] || (item[7:0] != ast_pkg::CH_SPACE && item[7:0] != ast_pkg::CH_TAB))
                counted++;
        end
        // flush whatever token is still open
        feed(8'($urandom_range(0, 255)), END_ITEM, PRED, NO_TOK);
        src_if.valid = 1'b0;

        while (pending_tokens.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_tokens.size() != 0) begin
            $display("%0t: %0d expected tokens never arrived", $time, pending_tokens.size());
            fail_count++;
        end

        $display("run covered %0d source items with %0d end marks, %0d tokens compared",
                 items_sent, end_marks, tokens_seen);
        $display("%0d of 17 token kinds seen, %0d tokens flagged in error",
                 $countones(kinds_seen), errors_seen);
        if (fail_count == 0) begin
            $display("assembly_source_tokenizer_test passed");
        end else begin
            $display("assembly_source_tokenizer_test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
design/ast_pkg.sv
design/ast_if.sv
design/ast_scan.sv
design/ast_obuf.sv
design/assembly_source_tokenizer.sv
design/ast_checker.sv
bench/assembly_source_tokenizer_test.sv
